// ===== rtl/hhst_pkg.sv =====
// Shared constants, command codes and control structs of the Hermite half-segment tessellator.
`default_nettype none

package hhst_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int TEN_W           = 16;
   localparam int SEG_W           = 6;
   localparam int U_W             = TEN_W + 1;
   localparam int NSQ_W           = 2 * SEG_W;
   localparam int NCUBE_W         = 3 * SEG_W;
   localparam int MUL_W           = NCUBE_W + 1;
   localparam int FRAC_SHIFT      = 18;
   localparam int SE_SHIFT        = 15;
   localparam int HEAD_W          = 42;
   localparam int CSR_IDX_W       = 2;
   localparam int U_ONE           = 16384;
   localparam int SEL_W           = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_TENSION  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENTS = 2'd1;

   localparam logic [TEN_W-1:0] TENSION_RST  = 16'd0;
   localparam logic [SEG_W-1:0] SEGMENTS_RST = 6'd10;

   localparam logic [SEL_W-1:0] SEL_UA = 3'd0;
   localparam logic [SEL_W-1:0] SEL_UB = 3'd1;
   localparam logic [SEL_W-1:0] SEL_A  = 3'd2;
   localparam logic [SEL_W-1:0] SEL_B  = 3'd3;
   localparam logic [SEL_W-1:0] SEL_T0 = 3'd4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_FIRST,
      OP_POW,
      OP_MINIT,
      OP_MSTEP,
      OP_MSTORE,
      OP_INIT,
      OP_STEP,
      OP_DINIT,
      OP_DIV,
      OP_RND
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [SEL_W-1:0] sel;
      logic             mul_top;
   } cmd_type;

   typedef struct packed {
      logic [SEG_W-1:0] segments;
      logic             seg_zero;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/hhst_ctrl.sv =====
// Sequencer of the tessellator: setup multiplies, per-point stepping, division and result strobe.
`default_nettype none

module hhst_ctrl #(
   parameter int COORD_WIDTH = hhst_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire hhst_pkg::status_type status,
   output hhst_pkg::cmd_type         cmd,
   output logic                      rsp_valid,
   output logic                      rsp_last
);

   localparam int STEPS = (hhst_pkg::MUL_W > COORD_WIDTH) ? hhst_pkg::MUL_W : COORD_WIDTH;
   localparam int CNT_W = $clog2(STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_FIRST, S_POW, S_MINIT, S_MSTEP, S_MSTORE,
      S_INIT, S_STEP, S_DINIT, S_DIV, S_RND
   } state_type;

   state_type                    state_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [hhst_pkg::SEL_W-1:0]   sel_ff;
   logic [hhst_pkg::SEG_W-1:0]   idx_ff;
   logic                         valid_ff;
   logic                         last_ff;
   logic                         mul_top;
   logic                         div_top;
   logic                         pt_last;

   assign mul_top = (cnt_ff == CNT_W'(hhst_pkg::MUL_W - 1));
   assign div_top = (cnt_ff == CNT_W'(COORD_WIDTH - 1));
   assign pt_last = (idx_ff == status.segments);

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_last  = last_ff;

   always_comb begin
      cmd.sel     = sel_ff;
      cmd.mul_top = mul_top;
      unique case (state_ff)
         S_IDLE:   cmd.op = start ? hhst_pkg::OP_LOAD : hhst_pkg::OP_NONE;
         S_FIRST:  cmd.op = hhst_pkg::OP_FIRST;
         S_POW:    cmd.op = hhst_pkg::OP_POW;
         S_MINIT:  cmd.op = hhst_pkg::OP_MINIT;
         S_MSTEP:  cmd.op = hhst_pkg::OP_MSTEP;
         S_MSTORE: cmd.op = hhst_pkg::OP_MSTORE;
         S_INIT:   cmd.op = hhst_pkg::OP_INIT;
         S_STEP:   cmd.op = hhst_pkg::OP_STEP;
         S_DINIT:  cmd.op = hhst_pkg::OP_DINIT;
         S_DIV:    cmd.op = hhst_pkg::OP_DIV;
         S_RND:    cmd.op = hhst_pkg::OP_RND;
         default:  cmd.op = hhst_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) state_ff <= S_FIRST;
            end
            S_FIRST: begin
               valid_ff <= 1'b1;
               last_ff  <= status.seg_zero;
               state_ff <= status.seg_zero ? S_IDLE : S_POW;
            end
            S_POW: begin
               sel_ff   <= hhst_pkg::SEL_UA;
               state_ff <= S_MINIT;
            end
            S_MINIT: begin
               cnt_ff   <= '0;
               state_ff <= S_MSTEP;
            end
            S_MSTEP: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (mul_top) state_ff <= S_MSTORE;
            end
            S_MSTORE: begin
               if (sel_ff == hhst_pkg::SEL_T0) begin
                  state_ff <= S_INIT;
               end else begin
                  sel_ff   <= sel_ff + 1'b1;
                  state_ff <= S_MINIT;
               end
            end
            S_INIT: begin
               idx_ff   <= hhst_pkg::SEG_W'(1);
               state_ff <= S_STEP;
            end
            S_STEP:  state_ff <= S_DINIT;
            S_DINIT: begin
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (div_top) state_ff <= S_RND;
            end
            S_RND: begin
               valid_ff <= 1'b1;
               last_ff  <= pt_last;
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= pt_last ? S_IDLE : S_STEP;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/hhst_datapath.sv =====
// Datapath of the tessellator: config registers, serial multiplier, forward differences, divider.
`default_nettype none

module hhst_datapath #(
   parameter int COORD_WIDTH = hhst_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [hhst_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [hhst_pkg::TEN_W-1:0]            csr_wdata,
   input  wire hhst_pkg::cmd_type                     cmd,
   output hhst_pkg::status_type                       status,
   input  wire logic signed [COORD_WIDTH-1:0]         p0 [3],
   input  wire logic signed [COORD_WIDTH-1:0]         p1 [3],
   input  wire logic signed [COORD_WIDTH-1:0]         p2 [3],
   input  wire logic signed [COORD_WIDTH-1:0]         p3 [3],
   output logic signed [COORD_WIDTH-1:0]              pos [3]
);

   localparam int CW     = COORD_WIDTH;
   localparam int NW     = CW + hhst_pkg::HEAD_W;
   localparam int MW     = hhst_pkg::MUL_W;
   localparam int FS     = hhst_pkg::FRAC_SHIFT;
   localparam int TOP_W  = NW - FS - CW;
   localparam int NC_W   = hhst_pkg::NCUBE_W;

   logic signed [hhst_pkg::TEN_W-1:0]  tension_ff;
   logic [hhst_pkg::SEG_W-1:0]         seg_cfg_ff;
   logic [hhst_pkg::SEG_W-1:0]         seg_ff;
   logic signed [hhst_pkg::U_W-1:0]    u_ff;
   logic [hhst_pkg::NSQ_W-1:0]         nsq_ff;
   logic [NC_W-1:0]                    ncube_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= hhst_pkg::TENSION_RST;
         seg_cfg_ff <= hhst_pkg::SEGMENTS_RST;
      end else if (csr_we) begin
         if (csr_index == hhst_pkg::CSR_TENSION)  tension_ff <= csr_wdata;
         if (csr_index == hhst_pkg::CSR_SEGMENTS) seg_cfg_ff <= csr_wdata[hhst_pkg::SEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == hhst_pkg::OP_LOAD) begin
         seg_ff <= seg_cfg_ff;
         nsq_ff <= hhst_pkg::NSQ_W'(seg_cfg_ff) * hhst_pkg::NSQ_W'(seg_cfg_ff);
         u_ff   <= hhst_pkg::U_W'(hhst_pkg::U_ONE) - hhst_pkg::U_W'(tension_ff);
      end
      if (cmd.op == hhst_pkg::OP_POW) begin
         ncube_ff <= NC_W'(nsq_ff) * NC_W'(seg_ff);
      end
   end

   assign status.segments = seg_ff;
   assign status.seg_zero = (seg_ff == '0);

   for (genvar c = 0; c < 3; c++) begin : g_lane
      logic signed [CW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
      logic signed [NW-1:0] ua_ff, ub_ff, a_ff, b_ff, t0_ff;
      logic signed [NW-1:0] acc_ff, d1_ff, d2_ff, d3_ff;
      logic signed [NW-1:0] mcand_ff, prod_ff;
      logic signed [MW-1:0] mplier_ff;
      logic [CW-1:0]        divq_ff;
      logic [NC_W:0]        rem_ff;
      logic                 ovf_ff, neg_ff, half_ff;
      logic signed [CW-1:0] pos_ff;

      logic signed [NW-1:0] se, c2, c3, c3x6, mag_s;
      logic [NW-1:0]        mag;
      logic [TOP_W-1:0]     head;
      logic [NC_W:0]        rem2;
      logic                 ge;
      logic [NC_W+1:0]      rem_x2;
      logic                 rup;
      logic [CW:0]          qr;
      logic [CW:0]          lim;
      logic signed [CW-1:0] sat_val;

      assign se    = (NW'(p2_ff) - NW'(p1_ff)) <<< hhst_pkg::SE_SHIFT;
      assign c2    = (se <<< 1) + se - (ua_ff <<< 1) - ub_ff;
      assign c3    = ua_ff + ub_ff - (se <<< 1);
      assign c3x6  = (c3 <<< 2) + (c3 <<< 1);
      assign mag_s = acc_ff[NW-1] ? -acc_ff : acc_ff;
      assign mag   = mag_s;
      assign head  = mag[NW-1:FS+CW];
      assign rem2  = {rem_ff[NC_W-1:0], divq_ff[CW-1]};
      assign ge    = (rem2 >= {1'b0, ncube_ff});
      assign rem_x2 = {rem_ff, half_ff};
      assign rup   = (rem_x2 >= (NC_W+2)'(ncube_ff));
      assign qr    = {1'b0, divq_ff} + (CW+1)'(rup);
      assign lim   = (CW+1)'(1) << (CW - 1);

      always_comb begin
         if (!neg_ff) begin
            if (ovf_ff || qr > lim - 1'b1) sat_val = {1'b0, {(CW-1){1'b1}}};
            else                           sat_val = qr[CW-1:0];
         end else begin
            if (ovf_ff || qr > lim) sat_val = {1'b1, {(CW-1){1'b0}}};
            else                    sat_val = -qr[CW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         case (cmd.op)
            hhst_pkg::OP_LOAD: begin
               p0_ff <= p0[c];
               p1_ff <= p1[c];
               p2_ff <= p2[c];
               p3_ff <= p3[c];
            end
            hhst_pkg::OP_FIRST: pos_ff <= p1_ff;
            hhst_pkg::OP_MINIT: begin
               prod_ff <= '0;
               case (cmd.sel)
                  hhst_pkg::SEL_UA: begin
                     mcand_ff  <= NW'(p2_ff) - NW'(p0_ff);
                     mplier_ff <= MW'(u_ff);
                  end
                  hhst_pkg::SEL_UB: begin
                     mcand_ff  <= NW'(p3_ff) - NW'(p1_ff);
                     mplier_ff <= MW'(u_ff);
                  end
                  hhst_pkg::SEL_A: begin
                     mcand_ff  <= ua_ff;
                     mplier_ff <= MW'({1'b0, nsq_ff});
                  end
                  hhst_pkg::SEL_B: begin
                     mcand_ff  <= c2;
                     mplier_ff <= MW'({1'b0, seg_ff});
                  end
                  default: begin
                     mcand_ff  <= NW'(p1_ff);
                     mplier_ff <= MW'({1'b0, ncube_ff});
                  end
               endcase
            end
            hhst_pkg::OP_MSTEP: begin
               if (mplier_ff[0]) prod_ff <= cmd.mul_top ? prod_ff - mcand_ff : prod_ff + mcand_ff;
               mcand_ff  <= mcand_ff <<< 1;
               mplier_ff <= mplier_ff >>> 1;
            end
            hhst_pkg::OP_MSTORE: begin
               case (cmd.sel)
                  hhst_pkg::SEL_UA: ua_ff <= prod_ff;
                  hhst_pkg::SEL_UB: ub_ff <= prod_ff;
                  hhst_pkg::SEL_A:  a_ff  <= prod_ff <<< 2;
                  hhst_pkg::SEL_B:  b_ff  <= prod_ff <<< 1;
                  default:          t0_ff <= prod_ff <<< FS;
               endcase
            end
            hhst_pkg::OP_INIT: begin
               acc_ff <= t0_ff;
               d1_ff  <= a_ff + b_ff + c3;
               d2_ff  <= (b_ff <<< 1) + c3x6;
               d3_ff  <= c3x6;
            end
            hhst_pkg::OP_STEP: begin
               acc_ff <= acc_ff + d1_ff;
               d1_ff  <= d1_ff + d2_ff;
               d2_ff  <= d2_ff + d3_ff;
            end
            hhst_pkg::OP_DINIT: begin
               neg_ff  <= acc_ff[NW-1];
               ovf_ff  <= (head >= TOP_W'(ncube_ff));
               rem_ff  <= head[NC_W:0];
               divq_ff <= mag[FS+CW-1:FS];
               half_ff <= mag[FS-1];
            end
            hhst_pkg::OP_DIV: begin
               rem_ff  <= ge ? rem2 - {1'b0, ncube_ff} : rem2;
               divq_ff <= {divq_ff[CW-2:0], ge};
            end
            hhst_pkg::OP_RND: pos_ff <= sat_val;
            default: ;
         endcase
      end

      assign pos[c] = pos_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/hermite_half_segment_tessellator.sv =====
// Top level of the Hermite half-segment tessellator: controller plus three-lane datapath.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+-------------------------------
//  request  | req_p0_x .. req_p3_z          | taken when start && !busy
//  result   | rsp_pos_x/y/z, rsp_last       | rsp_valid, one cycle, no stall
//  config   | csr_we, csr_index, csr_wdata  | write when csr_we
//
//  First point (P1) is output from S_FIRST after start. Setup then runs the UA, UB,
//  A, B and T0 products in the bit-serial multiplier; each further point is stepped, divided by
//  the one-bit-per-cycle restoring divider and rounded; busy stays high until the last point.
//  Reset is synchronous and restores tension 0, segments 10. The receiver cannot stall.
`default_nettype none

module hermite_half_segment_tessellator #(
   parameter int COORD_WIDTH = hhst_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p0_x,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p0_y,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p0_z,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p1_x,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p1_y,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p1_z,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p2_x,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p2_y,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p2_z,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p3_x,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p3_y,
   input  wire logic signed [COORD_WIDTH-1:0]      req_p3_z,
   output logic                                    rsp_valid,
   output logic signed [COORD_WIDTH-1:0]           rsp_pos_x,
   output logic signed [COORD_WIDTH-1:0]           rsp_pos_y,
   output logic signed [COORD_WIDTH-1:0]           rsp_pos_z,
   output logic                                    rsp_last,
   input  wire logic                               csr_we,
   input  wire logic [hhst_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [hhst_pkg::TEN_W-1:0]         csr_wdata
);

   hhst_pkg::cmd_type              cmd;
   hhst_pkg::status_type           status;
   logic signed [COORD_WIDTH-1:0]  p0 [3];
   logic signed [COORD_WIDTH-1:0]  p1 [3];
   logic signed [COORD_WIDTH-1:0]  p2 [3];
   logic signed [COORD_WIDTH-1:0]  p3 [3];
   logic signed [COORD_WIDTH-1:0]  pos [3];

   assign p0[0] = req_p0_x;
   assign p0[1] = req_p0_y;
   assign p0[2] = req_p0_z;
   assign p1[0] = req_p1_x;
   assign p1[1] = req_p1_y;
   assign p1[2] = req_p1_z;
   assign p2[0] = req_p2_x;
   assign p2[1] = req_p2_y;
   assign p2[2] = req_p2_z;
   assign p3[0] = req_p3_x;
   assign p3[1] = req_p3_y;
   assign p3[2] = req_p3_z;

   assign rsp_pos_x = pos[0];
   assign rsp_pos_y = pos[1];
   assign rsp_pos_z = pos[2];

   hhst_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .status    (status),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_last  (rsp_last)
   );

   hhst_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .p0        (p0),
      .p1        (p1),
      .p2        (p2),
      .p3        (p3),
      .pos       (pos)
   );

endmodule

`default_nettype wire

// ===== rtl/hhst_checker.sv =====
// Port-level assertions for the tessellator and their bind to the top level.
`default_nettype none

module hhst_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_last
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted item");

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid)
      else $error("last without valid");

   a_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on consecutive cycles");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("still busy on the last result");

   a_idle_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy |-> rsp_last)
      else $error("non-final result while idle");

endmodule

bind hermite_half_segment_tessellator hhst_checker u_hhst_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_last  (rsp_last)
);

`default_nettype wire
